[sv/iq_elastic_buffer_rx_core_assert.svh]
// assertion macros for the rx elastic buffer
`ifndef IQ_ELASTIC_BUFFER_RX_CORE_ASSERT_SVH
`define IQ_ELASTIC_BUFFER_RX_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IQEB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IQEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/iqeb_pkg.sv]
// types and constants of the rx elastic buffer
package iqeb_pkg;

   localparam int DEPTH       = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int PAIR_W      = 2 * SAMPLE_BITS;

   localparam int THR_W   = 11;
   localparam int OFF_W   = 10;
   localparam int CSR_W   = 11;
   localparam int CMP_W   = (ADDR_W > THR_W) ? ADDR_W : THR_W;
   localparam int SUM_W   = (ADDR_W > OFF_W) ? ADDR_W : OFF_W;

   localparam logic [THR_W-1:0] LOW_GAP_RESET  = THR_W'(DEPTH / 4);
   localparam logic [THR_W-1:0] HIGH_GAP_RESET = THR_W'(3 * DEPTH / 4);
   localparam logic [OFF_W-1:0] OFFSET_RESET   = OFF_W'(DEPTH / 2);

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_LOW_GAP      = 2'd0,
      CSR_HIGH_GAP     = 2'd1,
      CSR_START_OFFSET = 2'd2
   } csr_index_type;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [ADDR_W-1:0]      place_type;

endpackage

[sv/iqeb_if.sv]
// request and response channels of the rx elastic buffer
interface iqeb_req_if import iqeb_pkg::*; ();
   logic       valid;
   logic       ready;
   func_type   func;
   sample_type sample_i;
   sample_type sample_q;
   logic       block_first;
   logic       block_last;

   modport source (output valid, func, sample_i, sample_q, block_first, block_last,
                   input ready);
   modport sink (input valid, func, sample_i, sample_q, block_first, block_last,
                 output ready);
endinterface

interface iqeb_rsp_if import iqeb_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type out_i;
   sample_type out_q;

   modport source (output valid, out_i, out_q, input ready);
   modport sink (input valid, out_i, out_q, output ready);
endinterface

[sv/iq_elastic_buffer_rx_core.sv]
// Receive-side elastic buffer of I/Q pairs in one single-port-write, one-port-read RAM of
// DEPTH entries. After reset the RAM is swept to zero, one entry a cycle, so the block
// accepts no transfer until the sweep ends; register writes are taken at any time. A
// write of the last pair of a block also leaves a copy at the next place, written in
// the following cycle, when no transfer is taken. Reads stream at one per cycle unless
// the response side stalls; each result passes through the RAM output register and an
// output register, and a stalled response side stops new requests only once both hold
// data. Gap checks and pointer arithmetic wrap modulo DEPTH, which must be a power of two.
module iq_elastic_buffer_rx_core import iqeb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   iqeb_req_if.sink            req_chan,
   iqeb_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

`include "iq_elastic_buffer_rx_core_assert.svh"

   logic [PAIR_W-1:0] mem [DEPTH];

   // configuration
   logic [THR_W-1:0] low_gap_ff;
   logic [THR_W-1:0] high_gap_ff;
   logic [OFF_W-1:0] start_offset_ff;

   // control state
   place_type wp_ff, wp_in;
   place_type rp_ff, rp_in;
   logic      started_ff, started_in;
   logic      clr_ff, clr_in;
   place_type clr_addr_ff, clr_addr_in;
   logic      pend_ff, pend_in;
   place_type pend_addr_ff, pend_addr_in;
   logic [PAIR_W-1:0] pend_data_ff, pend_data_in;
   logic      rd_vld_ff, rd_vld_in;
   logic      out_vld_ff, out_vld_in;
   logic [PAIR_W-1:0] rd_data_ff;
   logic [PAIR_W-1:0] out_data_ff;

   // datapath
   logic              acc, wr_acc, rd_acc, move;
   place_type         gap, wa, rd_addr, rd_first;
   logic [SUM_W-1:0]  off_sum;
   logic              step_back, step_fwd;
   logic              mem_we;
   place_type         mem_waddr;
   logic [PAIR_W-1:0] mem_wdata;

   assign move   = rd_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !clr_ff && !pend_ff && (!rd_vld_ff || move);
   assign acc    = req_chan.valid && req_chan.ready;
   assign wr_acc = acc && (req_chan.func == FUNC_WRITE);
   assign rd_acc = acc && (req_chan.func == FUNC_READ);

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.out_i = out_data_ff[PAIR_W-1:SAMPLE_BITS];
   assign rsp_chan.out_q = out_data_ff[SAMPLE_BITS-1:0];

   // gap check and slip of the write place
   always_comb begin
      gap       = started_ff ? place_type'(wp_ff - rp_ff) : '0;
      step_back = CMP_W'(gap) > CMP_W'(high_gap_ff);
      step_fwd  = CMP_W'(gap) < CMP_W'(low_gap_ff);
      wa        = wp_ff;
      if (req_chan.block_first) begin
         if (step_back) begin
            wa = wa - place_type'(1);
         end
         if (step_fwd) begin
            wa = wa + place_type'(1);
         end
      end
   end

   // read place, set ahead of the writer on the first read
   always_comb begin
      off_sum  = SUM_W'(wp_ff) + SUM_W'(start_offset_ff);
      rd_first = off_sum[ADDR_W-1:0];
      rd_addr  = started_ff ? rp_ff : rd_first;
   end

   // ram write port: clearing sweep, then copy of a last pair, then new writes
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wa;
      mem_wdata = {req_chan.sample_i, req_chan.sample_q};
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_data_ff;
      end else if (wr_acc) begin
         mem_we    = 1'b1;
      end
   end

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      started_in   = started_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      pend_in      = 1'b0;
      pend_addr_in = wa + place_type'(1);
      pend_data_in = {req_chan.sample_i, req_chan.sample_q};
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + place_type'(1);
         if (clr_addr_ff == place_type'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
      if (wr_acc) begin
         // the pointer rests on the copy of a last pair, so it steps one place either way
         wp_in   = wa + place_type'(1);
         pend_in = req_chan.block_last;
      end
      if (rd_acc) begin
         rp_in      = rd_addr + place_type'(1);
         started_in = 1'b1;
      end
      rd_vld_in  = rd_acc || (rd_vld_ff && !move);
      out_vld_in = move || (out_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         started_ff  <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         started_ff  <= started_in;
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         rd_vld_ff   <= rd_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_gap_ff      <= LOW_GAP_RESET;
         high_gap_ff     <= HIGH_GAP_RESET;
         start_offset_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_GAP:      low_gap_ff      <= csr_wdata[THR_W-1:0];
            CSR_HIGH_GAP:     high_gap_ff     <= csr_wdata[THR_W-1:0];
            CSR_START_OFFSET: start_offset_ff <= csr_wdata[OFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (wr_acc) begin
         pend_addr_ff <= pend_addr_in;
         pend_data_ff <= pend_data_in;
      end
      if (move) begin
         out_data_ff <= rd_data_ff;
      end
   end

   // ram: one write and one registered read per cycle, never to the same transfer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_acc) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `IQEB_ASSERT_NOW(a_no_transfer_in_sweep, clock, reset, clr_ff || pend_ff, !acc, "transfer taken while the ram write port is busy")
   `IQEB_ASSERT_NEXT(a_last_gets_copy, clock, reset, wr_acc && req_chan.block_last, pend_ff && mem_we && (mem_waddr == wp_ff), "copy of a last pair not written at the write place")
   `IQEB_ASSERT_NEXT(a_read_held, clock, reset, rd_vld_ff && out_vld_ff && !rsp_chan.ready, rd_vld_ff && out_vld_ff && $stable(rd_data_ff), "read data lost behind a stalled output")

endmodule
